@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the text glyph block.
// Needs a clock named clk and a synchronous reset named rst in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define TGO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define TGO_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/tgo_pkg.sv @@
// Types, constants and the 5x7 font for the text glyph to display byte block.
// No dependencies; the block's modules and the testbench import it.
package tgo_pkg;

  // Glyph geometry.
  localparam int GLYPH_COLUMNS = 5;
  localparam int CHAR_PITCH    = 6;

  // Printable character range.
  localparam logic [7:0] CODE_FIRST = 8'h20;
  localparam logic [7:0] CODE_LAST  = 8'h7E;

  // Display controller command bytes.
  localparam logic [7:0] CMD_PAGE_MODE = 8'h22;
  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_FIXED     = 8'h04;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

  // Steps of one character run.
  localparam logic [3:0] STEP_PAGE_MODE = 4'd0;
  localparam logic [3:0] STEP_PAGE      = 4'd1;
  localparam logic [3:0] STEP_FIXED     = 4'd2;
  localparam logic [3:0] STEP_COL_LOW   = 4'd3;
  localparam logic [3:0] STEP_COL_HIGH  = 4'd4;
  localparam logic [3:0] STEP_GLYPH0    = 4'd5;
  localparam logic [3:0] STEP_GLYPH1    = 4'd6;
  localparam logic [3:0] STEP_GLYPH2    = 4'd7;
  localparam logic [3:0] STEP_GLYPH3    = 4'd8;
  localparam logic [3:0] STEP_GLYPH4    = 4'd9;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_START_PAGE   = 3'd0,
    REG_START_COLUMN = 3'd1,
    REG_COLUMN_BASE  = 3'd2,
    REG_LINE_WIDTH   = 3'd3,
    REG_LAST_PAGE    = 3'd4
  } reg_index_t;

  // Configuration register reset values.
  localparam logic [2:0] RST_START_PAGE   = 3'd0;
  localparam logic [6:0] RST_START_COLUMN = 7'd0;
  localparam logic [7:0] RST_COLUMN_BASE  = 8'd28;
  localparam logic [7:0] RST_LINE_WIDTH   = 8'd72;
  localparam logic [2:0] RST_LAST_PAGE    = 3'd4;

  // Configuration register set as seen by the front end.
  typedef struct packed {
    logic [2:0] start_page;
    logic [6:0] start_column;
    logic [7:0] column_base;
    logic [7:0] line_width;
    logic [2:0] last_page;
  } cfg_t;

  // One character run queued between front and back end.
  typedef struct packed {
    logic [3:0] page;
    logic [7:0] addr;
    logic [6:0] glyph_idx;
  } job_t;

  // Font ROM: column 0 in the top byte, column 4 in the bottom byte.
  function automatic logic [39:0] font_glyph(input logic [6:0] idx);
    logic [39:0] g;
    case (idx)
      7'd0:  g = 40'h0000000000;
      7'd1:  g = 40'h00004f0000;
      7'd2:  g = 40'h0007000700;
      7'd3:  g = 40'h147f147f14;
      7'd4:  g = 40'h242a7f2a12;
      7'd5:  g = 40'h2313086462;
      7'd6:  g = 40'h3649552250;
      7'd7:  g = 40'h0005030000;
      7'd8:  g = 40'h001c224100;
      7'd9:  g = 40'h0041221c00;
      7'd10: g = 40'h14083e0814;
      7'd11: g = 40'h08083e0808;
      7'd12: g = 40'h0050300000;
      7'd13: g = 40'h0808080808;
      7'd14: g = 40'h0060600000;
      7'd15: g = 40'h2010080402;
      7'd16: g = 40'h3e5149453e;
      7'd17: g = 40'h00427f4000;
      7'd18: g = 40'h4261514946;
      7'd19: g = 40'h2141454b31;
      7'd20: g = 40'h1814127f10;
      7'd21: g = 40'h2745454539;
      7'd22: g = 40'h3c4a494930;
      7'd23: g = 40'h0171090503;
      7'd24: g = 40'h3649494936;
      7'd25: g = 40'h064949291e;
      7'd26: g = 40'h0036360000;
      7'd27: g = 40'h0056360000;
      7'd28: g = 40'h0814224100;
      7'd29: g = 40'h1414141414;
      7'd30: g = 40'h0041221408;
      7'd31: g = 40'h0201510906;
      7'd32: g = 40'h324979413e;
      7'd33: g = 40'h7e1111117e;
      7'd34: g = 40'h7f49494936;
      7'd35: g = 40'h3e41414122;
      7'd36: g = 40'h7f4141221c;
      7'd37: g = 40'h7f49494941;
      7'd38: g = 40'h7f09090901;
      7'd39: g = 40'h3e4149497a;
      7'd40: g = 40'h7f0808087f;
      7'd41: g = 40'h00417f4100;
      7'd42: g = 40'h2040413f01;
      7'd43: g = 40'h7f08142241;
      7'd44: g = 40'h7f40404040;
      7'd45: g = 40'h7f020c027f;
      7'd46: g = 40'h7f0408107f;
      7'd47: g = 40'h3e4141413e;
      7'd48: g = 40'h7f09090906;
      7'd49: g = 40'h3e4151215e;
      7'd50: g = 40'h7f09192946;
      7'd51: g = 40'h4649494931;
      7'd52: g = 40'h01017f0101;
      7'd53: g = 40'h3f4040403f;
      7'd54: g = 40'h1f2040201f;
      7'd55: g = 40'h3f4038403f;
      7'd56: g = 40'h6314081463;
      7'd57: g = 40'h0708700807;
      7'd58: g = 40'h6151494543;
      7'd59: g = 40'h007f414100;
      7'd60: g = 40'h0204081020;
      7'd61: g = 40'h0041417f00;
      7'd62: g = 40'h0402010204;
      7'd63: g = 40'h4040404040;
      7'd64: g = 40'h0001020400;
      7'd65: g = 40'h2054545478;
      7'd66: g = 40'h7f48444438;
      7'd67: g = 40'h3844444420;
      7'd68: g = 40'h384444487f;
      7'd69: g = 40'h3854545418;
      7'd70: g = 40'h087e090102;
      7'd71: g = 40'h0c5252523e;
      7'd72: g = 40'h7f08040478;
      7'd73: g = 40'h00447d4000;
      7'd74: g = 40'h2040443d00;
      7'd75: g = 40'h7f10284400;
      7'd76: g = 40'h00417f4000;
      7'd77: g = 40'h7c04180478;
      7'd78: g = 40'h7c08040478;
      7'd79: g = 40'h3844444438;
      7'd80: g = 40'h7c14141408;
      7'd81: g = 40'h081414187c;
      7'd82: g = 40'h7c08040408;
      7'd83: g = 40'h4854545420;
      7'd84: g = 40'h043f444020;
      7'd85: g = 40'h3c4040207c;
      7'd86: g = 40'h1c2040201c;
      7'd87: g = 40'h3c4030403c;
      7'd88: g = 40'h4428102844;
      7'd89: g = 40'h0c5050503c;
      7'd90: g = 40'h4464544c44;
      7'd91: g = 40'h0008364100;
      7'd92: g = 40'h00007f0000;
      7'd93: g = 40'h0041360800;
      7'd94: g = 40'h08082a1c08;
      default: g = 40'h0000000000;
    endcase
    return g;
  endfunction

endpackage

@@ hw/rtl/tgo_in_if.sv @@
// Input character channel: valid/ready handshake with character payload.
// No dependencies.
interface tgo_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       text_end;

  modport source (output valid, output char_code, output text_end, input ready);
  modport sink   (input valid, input char_code, input text_end, output ready);
endinterface

@@ hw/rtl/tgo_out_if.sv @@
// Output byte channel: valid/ready handshake with display byte payload.
// No dependencies.
interface tgo_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_data;
  logic       last;

  modport source (output valid, output out_byte, output is_data, output last, input ready);
  modport sink   (input valid, input out_byte, input is_data, input last, output ready);
endinterface

@@ hw/rtl/tgo_cfg_if.sv @@
// Configuration write channel: valid/ready handshake with index and data.
// No dependencies.
interface tgo_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/tgo_queue.sv @@
// Short register queue of character runs between the front and back end.
// Depends on tgo_pkg for job_t.
module tgo_queue
  import tgo_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic space,
  input  logic pop,
  output job_t pop_job,
  output logic avail
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign space   = (count != CNT_FULL);
  assign avail   = (count != '0);
  assign pop_job = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

@@ hw/rtl/tgo_front.sv @@
// Front end: accepts characters, keeps the cursor and queues character runs.
// Depends on tgo_pkg and the input channel interface.
module tgo_front
  import tgo_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  tgo_in_if.sink     in_ch,
  input  cfg_t       cfg,
  input  logic       q_space,
  output logic       q_push,
  output job_t       q_job
);

  logic [7:0] cursor_column;
  logic [3:0] cursor_page;
  logic       stopped;

  logic       accept;
  logic       printable;
  logic       draw;
  logic [7:0] col_adv;
  logic       wrap;
  logic [7:0] cursor_column_next;
  logic [3:0] cursor_page_next;

  assign in_ch.ready = q_space;
  assign accept      = in_ch.valid && in_ch.ready;

  // Classify the character.
  always_comb begin
    printable = in_ch.char_code inside {[CODE_FIRST:CODE_LAST]};
    draw      = !in_ch.text_end && !stopped && printable;
  end

  // Cursor advance and line wrap: column + pitch > width - pitch.
  always_comb begin
    col_adv = cursor_column + 8'(CHAR_PITCH);
    wrap    = ({1'b0, col_adv} + 9'(CHAR_PITCH)) > {1'b0, cfg.line_width};
    cursor_column_next = wrap ? {1'b0, cfg.start_column} : col_adv;
    cursor_page_next   = wrap ? cursor_page + 4'd1 : cursor_page;
  end

  // Job handed to the back end.
  assign q_push          = accept && draw;
  assign q_job.page      = cursor_page;
  assign q_job.addr      = cfg.column_base + cursor_column;
  assign q_job.glyph_idx = 7'(in_ch.char_code - CODE_FIRST);

  // Cursor state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= {1'b0, RST_START_COLUMN};
      cursor_page   <= {1'b0, RST_START_PAGE};
      stopped       <= 1'b0;
    end else if (accept) begin
      if (in_ch.text_end) begin
        cursor_column <= {1'b0, cfg.start_column};
        cursor_page   <= {1'b0, cfg.start_page};
        stopped       <= 1'b0;
      end else if (draw) begin
        cursor_column <= cursor_column_next;
        cursor_page   <= cursor_page_next;
        stopped       <= cursor_page_next > {1'b0, cfg.last_page};
      end
    end
  end

endmodule

@@ hw/rtl/tgo_back.sv @@
// Back end: turns each queued character run into ten display bytes.
// Depends on tgo_pkg (font ROM, command bytes) and the output channel interface.
module tgo_back
  import tgo_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_avail,
  input  job_t       q_job,
  output logic       q_pop,
  tgo_out_if.source  out_ch
);

  logic        busy;
  logic [3:0]  step;
  logic [3:0]  page;
  logic [7:0]  addr;
  logic [39:0] glyph;

  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_is_data;
  logic        out_last;

  logic        advance;
  logic [7:0]  step_byte;

  assign advance = !out_valid || out_ch.ready;
  assign q_pop   = q_avail && (!busy || (advance && step == STEP_GLYPH4));

  assign out_ch.valid    = out_valid;
  assign out_ch.out_byte = out_byte;
  assign out_ch.is_data  = out_is_data;
  assign out_ch.last     = out_last;

  // Byte for the current step of the run.
  always_comb begin
    case (step)
      STEP_PAGE_MODE: step_byte = CMD_PAGE_MODE;
      STEP_PAGE:      step_byte = CMD_PAGE_BASE + {4'd0, page};
      STEP_FIXED:     step_byte = CMD_FIXED;
      STEP_COL_LOW:   step_byte = {4'd0, addr[3:0]};
      STEP_COL_HIGH:  step_byte = CMD_COL_HIGH | {4'd0, addr[7:4]};
      STEP_GLYPH0:    step_byte = glyph[39:32];
      STEP_GLYPH1:    step_byte = glyph[31:24];
      STEP_GLYPH2:    step_byte = glyph[23:16];
      STEP_GLYPH3:    step_byte = glyph[15:8];
      STEP_GLYPH4:    step_byte = glyph[7:0];
      default:        step_byte = 8'h00;
    endcase
  end

  // Run control and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= STEP_PAGE_MODE;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= busy;
      end
      if (q_pop) begin
        busy <= 1'b1;
        step <= STEP_PAGE_MODE;
      end else if (advance && busy) begin
        if (step == STEP_GLYPH4) begin
          busy <= 1'b0;
        end else begin
          step <= step + 4'd1;
        end
      end
    end
  end

  // Run payload and output register.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      page  <= q_job.page;
      addr  <= q_job.addr;
      glyph <= font_glyph(q_job.glyph_idx);
    end
    if (advance && busy) begin
      out_byte    <= step_byte;
      out_is_data <= (step >= STEP_GLYPH0);
      out_last    <= (step == STEP_GLYPH4);
    end
  end

endmodule

@@ hw/rtl/text_glyph_to_oled_byte_stream.sv @@
// Channel   Dir  Payload                      Transfer when
// in_ch     in   char_code[8], text_end[1]    in_ch.valid && in_ch.ready
// out_ch    out  out_byte[8], is_data, last   out_ch.valid && out_ch.ready
// cfg_ch    in   index[3], data[8]            cfg_ch.valid && cfg_ch.ready
//
// A printable character that is drawn gives ten output transfers, one per cycle while
// the sink is ready, so a steady stream is paced by the back end emitting one byte a
// cycle. Ignored characters and text ends queue no run. The front end stalls only
// when the job queue is full; the output stalls only on out_ch.ready. Reset
// (synchronous) restores the register defaults and homes the cursor.
// Depends on tgo_pkg, the channel interfaces, tgo_front, tgo_queue, tgo_back.
`include "assert_macros.svh"

module text_glyph_to_oled_byte_stream
  import tgo_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  tgo_in_if.sink    in_ch,
  tgo_out_if.source out_ch,
  tgo_cfg_if.sink   cfg_ch
);

  cfg_t cfg;
  logic q_push;
  job_t q_push_job;
  logic q_space;
  logic q_pop;
  job_t q_pop_job;
  logic q_avail;

  // Configuration registers; writes beyond the list are dropped.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_page   <= RST_START_PAGE;
      cfg.start_column <= RST_START_COLUMN;
      cfg.column_base  <= RST_COLUMN_BASE;
      cfg.line_width   <= RST_LINE_WIDTH;
      cfg.last_page    <= RST_LAST_PAGE;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_START_PAGE:   cfg.start_page   <= cfg_ch.data[2:0];
        REG_START_COLUMN: cfg.start_column <= cfg_ch.data[6:0];
        REG_COLUMN_BASE:  cfg.column_base  <= cfg_ch.data;
        REG_LINE_WIDTH:   cfg.line_width   <= cfg_ch.data;
        REG_LAST_PAGE:    cfg.last_page    <= cfg_ch.data[2:0];
        default: ;
      endcase
    end
  end

  // Front end: cursor and classification.
  tgo_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .cfg     (cfg),
    .q_space (q_space),
    .q_push  (q_push),
    .q_job   (q_push_job)
  );

  // Job queue between the two ends.
  tgo_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_push_job),
    .space    (q_space),
    .pop      (q_pop),
    .pop_job  (q_pop_job),
    .avail    (q_avail)
  );

  // Back end: byte sequencer and output register.
  tgo_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_avail (q_avail),
    .q_job   (q_pop_job),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  // A run's last byte is always a data byte.
  `TGO_ASSERT(a_last_is_data, (out_ch.valid && out_ch.last) |-> out_ch.is_data, "last on a command byte")

  // After the last byte of a run, the next byte shown opens a new run with a command.
  `TGO_ASSERT(a_run_opens_cmd, (out_ch.valid && out_ch.ready && out_ch.last) |=> (!out_ch.valid || !out_ch.is_data), "run does not open with a command")

  // Within a run the bytes follow without a gap.
  `TGO_ASSERT(a_run_no_gap, (out_ch.valid && out_ch.ready && !out_ch.last) |=> out_ch.valid, "gap inside a character run")

  // A text end never queues a run.
  `TGO_ASSERT_ALWAYS(a_end_no_job, (in_ch.valid && in_ch.ready && in_ch.text_end) |-> !q_push, "text end queued a run")

endmodule

@@ dv/tb_text_glyph_to_oled_byte_stream.sv @@
// Self-checking testbench for the text glyph to display byte stream block.
// Needs tgo_pkg, the three channel interfaces and the block itself.
// A scoreboard predicts every command and glyph byte from the accepted characters.
module tb_text_glyph_to_oled_byte_stream
  import tgo_pkg::*;
();

  localparam int REG_COUNT       = 5;
  localparam int REG_SLOTS       = 8;
  localparam int PHASES          = 5;
  localparam int ITEMS_PER_PHASE = 60;
  localparam int SETTLE_CYCLES   = 12;
  localparam int HOLD_CYCLES     = 400;
  localparam int HOLD_AFTER      = 140;
  localparam int CALM_FROM       = 260;
  localparam int CALM_TO         = 330;
  localparam int IDLE_PERCENT    = 9;

  // 5x7 font, one entry per printable code, column 0 in the top byte.
  localparam logic [39:0] FONT_COLUMNS [0:94] = '{
    40'h0000000000, 40'h00004f0000, 40'h0007000700, 40'h147f147f14, 40'h242a7f2a12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001c224100, 40'h0041221c00,
    40'h14083e0814, 40'h08083e0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
    40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503, 40'h3649494936,
    40'h064949291e, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413e, 40'h7e1111117e, 40'h7f49494936,
    40'h3e41414122, 40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
    40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
    40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e, 40'h7f09090906, 40'h3e4151215e,
    40'h7f09192946, 40'h4649494931, 40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f,
    40'h3f4038403f, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
    40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
    40'h2054545478, 40'h7f48444438, 40'h3844444420, 40'h384444487f, 40'h3854545418,
    40'h087e090102, 40'h0c5252523e, 40'h7f08040478, 40'h00447d4000, 40'h2040443d00,
    40'h7f10284400, 40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
    40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420, 40'h043f444020,
    40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c, 40'h4428102844, 40'h0c5050503c,
    40'h4464544c44, 40'h0008364100, 40'h00007f0000, 40'h0041360800, 40'h08082a1c08
  };

  typedef struct packed {
    logic [7:0] value;
    logic       is_data;
    logic       last;
  } disp_byte_t;

  // Cursor tracking and the queue of display bytes still owed by the block.
  class oled_byte_board;
    logic [2:0]  start_page;
    logic [6:0]  start_column;
    logic [7:0]  column_base;
    logic [7:0]  line_width;
    logic [2:0]  last_page;
    logic [7:0]  cursor_column;
    logic [3:0]  cursor_page;
    logic        halted;
    disp_byte_t  owed_bytes[$];
    int          faults;

    function new();
      start_page   = RST_START_PAGE;
      start_column = RST_START_COLUMN;
      column_base  = RST_COLUMN_BASE;
      line_width   = RST_LINE_WIDTH;
      last_page    = RST_LAST_PAGE;
      faults       = 0;
      home();
    endfunction

    function void home();
      cursor_column = {1'b0, start_column};
      cursor_page   = {1'b0, start_page};
      halted        = 1'b0;
    endfunction

    function void write_reg(logic [2:0] index, logic [7:0] data);
      case (index)
        REG_START_PAGE:   start_page   = data[2:0];
        REG_START_COLUMN: start_column = data[6:0];
        REG_COLUMN_BASE:  column_base  = data;
        REG_LINE_WIDTH:   line_width   = data;
        REG_LAST_PAGE:    last_page    = data[2:0];
        default: ;
      endcase
    endfunction

    function void owe(logic [7:0] value, logic is_data, logic last);
      disp_byte_t b;
      b.value   = value;
      b.is_data = is_data;
      b.last    = last;
      owed_bytes.push_back(b);
    endfunction

    // Work out the ten bytes of one character and move the cursor on.
    function void note_char(logic [7:0] code, logic text_end);
      logic [7:0] addr;
      logic [6:0] idx;
      if (text_end) begin
        home();
        return;
      end
      if (halted || code < CODE_FIRST || code > CODE_LAST) return;
      addr = column_base + cursor_column;
      idx  = 7'(code - CODE_FIRST);
      owe(CMD_PAGE_MODE, 1'b0, 1'b0);
      owe(CMD_PAGE_BASE + {4'h0, cursor_page}, 1'b0, 1'b0);
      owe(CMD_FIXED, 1'b0, 1'b0);
      owe({4'h0, addr[3:0]}, 1'b0, 1'b0);
      owe(CMD_COL_HIGH | {4'h0, addr[7:4]}, 1'b0, 1'b0);
      for (int g = 0; g < GLYPH_COLUMNS; g++) begin
        owe(FONT_COLUMNS[idx][39 - 8 * g -: 8], 1'b1, g == GLYPH_COLUMNS - 1);
      end
      // Advance, wrap at the end of the line and go quiet past the last page.
      cursor_column = cursor_column + 8'(CHAR_PITCH);
      if (int'(cursor_column) > int'(line_width) - CHAR_PITCH) begin
        cursor_column = {1'b0, start_column};
        cursor_page   = cursor_page + 4'd1;
      end
      if (cursor_page > {1'b0, last_page}) halted = 1'b1;
    endfunction

    function void check_byte(logic [7:0] value, logic is_data, logic last);
      disp_byte_t want;
      if (owed_bytes.size() == 0) begin
        $display("%0t: byte with nothing owed: expected none, actual %h is_data %b last %b",
                 $time, value, is_data, last);
        faults++;
        return;
      end
      want = owed_bytes.pop_front();
      if (value !== want.value) begin
        $display("%0t: out_byte expected %h actual %h", $time, want.value, value);
        faults++;
      end
      if (is_data !== want.is_data) begin
        $display("%0t: is_data expected %b actual %b", $time, want.is_data, is_data);
        faults++;
      end
      if (last !== want.last) begin
        $display("%0t: last expected %b actual %b", $time, want.last, last);
        faults++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int   chars_taken = 0;
  oled_byte_board board;

  tgo_in_if  in_ch ();
  tgo_out_if out_ch ();
  tgo_cfg_if cfg_ch ();

  text_glyph_to_oled_byte_stream DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Both sides run without gaps for a while in the middle of the random part.
  function automatic bit calm_window();
    return chars_taken >= CALM_FROM && chars_taken < CALM_TO;
  endfunction

  // Sample every transfer on the edge at which it happens.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        board.check_byte(out_ch.out_byte, out_ch.is_data, out_ch.last);
      end
      if (in_ch.valid && in_ch.ready) begin
        board.note_char(in_ch.char_code, in_ch.text_end);
        chars_taken <= chars_taken + 1;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        board.write_reg(cfg_ch.index, cfg_ch.data);
      end
    end
  end

  // Byte sink: random stalls, one long hold-off that backs up the input side.
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && chars_taken >= HOLD_AFTER) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= calm_window() || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // Offer one character and wait for its transfer; valid stays high afterwards.
  task automatic offer_char(input logic [7:0] code, input logic text_end);
    while (!calm_window() && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= code;
    in_ch.text_end  <= text_end;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [7:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Stop offering, wait for the next edge so the last transfer has been noted, let every
  // owed byte come out, then give ignored items time to clear.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.owed_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all five registers, then the unused indexes, which must change nothing.
  task automatic configure(input logic [7:0] page0, input logic [7:0] col0,
                           input logic [7:0] base, input logic [7:0] width,
                           input logic [7:0] page_end);
    write_reg(REG_START_PAGE, page0);
    write_reg(REG_START_COLUMN, col0);
    write_reg(REG_COLUMN_BASE, base);
    write_reg(REG_LINE_WIDTH, width);
    write_reg(REG_LAST_PAGE, page_end);
    for (int k = REG_COUNT; k < REG_SLOTS; k++) write_reg(3'(k), 8'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int counted;
    int r;
    logic [7:0] code;
    board = new();
    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.char_code <= 8'h00;
    in_ch.text_end  <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= 3'd0;
    cfg_ch.data     <= 8'h00;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Register defaults: both ends of the printable range and the invalid codes.
    offer_char(CODE_FIRST, 1'b0);
    offer_char(CODE_LAST, 1'b0);
    offer_char(8'h41, 1'b0);
    offer_char(CODE_FIRST - 8'd1, 1'b0);
    offer_char(CODE_LAST + 8'd1, 1'b0);
    offer_char(8'h00, 1'b0);
    offer_char(8'hFF, 1'b0);
    offer_char(8'hFF, 1'b1);
    offer_char(8'h30, 1'b0);

    // Start page beyond the last page, line narrower than the pitch, address wrap.
    drain();
    configure(8'd7, 8'd127, 8'd255, 8'd0, 8'd0);
    offer_char(8'h00, 1'b1);
    offer_char(8'h48, 1'b0);
    offer_char(8'h49, 1'b0);
    offer_char(8'h7F, 1'b1);
    offer_char(8'h4A, 1'b0);

    // Stop after a wrap on the last page, silence, then a new text.
    drain();
    configure(8'd0, 8'd0, 8'd0, 8'd12, 8'd0);
    offer_char(8'h20, 1'b1);
    offer_char(8'h61, 1'b0);
    offer_char(8'h62, 1'b0);
    offer_char(8'h63, 1'b0);
    offer_char(8'h01, 1'b1);
    offer_char(8'h64, 1'b0);

    // Random text under several register settings, extremes first.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: configure(8'd0, 8'd0, 8'd0, 8'd128, 8'd7);
        1: configure(8'd7, 8'd127, 8'd255, 8'd255, 8'd7);
        2: configure(8'd2, 8'd3, 8'd200, 8'd6, 8'd5);
        3: configure(8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom_range(0, 255)), 8'($urandom));
        default: configure(8'($urandom_range(0, 7)), 8'($urandom_range(0, 40)),
                           8'($urandom), 8'($urandom_range(6, 48)),
                           8'($urandom_range(0, 7)));
      endcase
      offer_char(8'($urandom), 1'b1);
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        if (r < 7) begin
          offer_char(8'($urandom), 1'b1);
          counted++;
        end else if (r < 20) begin
          if ($urandom_range(0, 1) == 0) begin
            code = 8'($urandom_range(0, CODE_FIRST - 1));
          end else begin
            code = 8'($urandom_range(CODE_LAST + 1, 255));
          end
          offer_char(code, 1'b0);
        end else begin
          offer_char(8'($urandom_range(CODE_FIRST, CODE_LAST)), 1'b0);
          counted++;
        end
      end
    end

    drain();
    if (board.faults == 0) begin
      $display("text_glyph_to_oled_byte_stream verification clean");
    end else begin
      $display("text_glyph_to_oled_byte_stream verification failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #400000;
    $display("text_glyph_to_oled_byte_stream verification failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/tgo_pkg.sv
hw/rtl/tgo_in_if.sv
hw/rtl/tgo_out_if.sv
hw/rtl/tgo_cfg_if.sv
hw/rtl/tgo_queue.sv
hw/rtl/tgo_front.sv
hw/rtl/tgo_back.sv
hw/rtl/text_glyph_to_oled_byte_stream.sv
dv/tb_text_glyph_to_oled_byte_stream.sv
